>>> src/bqp_pkg.sv
// Shared types, constants and codes for the box-constrained QP solver.
`default_nettype none
package bqp_pkg;

    localparam int NumVars   = 6;
    localparam int IdxW      = $clog2(NumVars);
    localparam int HessDepth = NumVars * NumVars;
    localparam int HessAw    = $clog2(HessDepth);

    localparam logic [7:0] SweepReset = 8'd10;

    typedef enum logic [2:0] {
        ACT_HESS  = 3'd0,
        ACT_GRAD  = 3'd1,
        ACT_LOWER = 3'd2,
        ACT_UPPER = 3'd3,
        ACT_SOLVE = 3'd4
    } action_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [2:0]         row;
        logic [2:0]         column;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         var_index;
        logic signed [31:0] step_value;
        logic               last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ROW,
        ST_MAC,
        ST_NUM,
        ST_DIV,
        ST_CLAMP,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            load;
        logic            clear_x;
        logic            row_init;
        logic            mac;
        logic            num;
        logic            div_step;
        logic            clamp;
        logic            emit;
        logic [IdxW-1:0] row;
        logic [IdxW-1:0] col;
        logic            emit_last;
    } dp_cmd_t;

endpackage
`default_nettype wire

>>> src/bqp_datapath.sv
// Datapath: stores, multiply-accumulate, serial divider and clamp.
`default_nettype none
module bqp_datapath
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bqp_pkg::dp_cmd_t  cmd,
    input  wire bqp_pkg::in_word_t in_word,
    output bqp_pkg::out_word_t     out_word
);

    localparam int HessAwL = bqp_pkg::HessAw;

    logic signed [31:0] hess_mem [bqp_pkg::HessDepth];
    logic signed [31:0] grad_reg  [bqp_pkg::NumVars];
    logic signed [31:0] lower_reg [bqp_pkg::NumVars];
    logic signed [31:0] upper_reg [bqp_pkg::NumVars];
    logic signed [31:0] x_reg     [bqp_pkg::NumVars];

    logic signed [31:0] h_rd_reg;
    logic signed [31:0] diag_reg;
    logic signed [63:0] prod_reg;
    logic               prod_vld_reg;
    logic               sum_vld_reg;
    logic               mac_d_reg;
    logic [bqp_pkg::IdxW-1:0] col_d_reg;
    logic signed [50:0] sigma_reg;
    logic [47:0]        rem_reg;
    logic [63:0]        quo_reg;
    logic               neg_reg;
    logic               zero_reg;
    logic signed [31:0] xnew;
    logic [HessAwL-1:0] rd_addr;
    logic signed [50:0] num_full;
    logic [47:0]        num_mag;
    logic [48:0]        trial;
    logic signed [64:0] quo_s;

    // Hessian memory: one write port for loads, one registered read port.
    always_comb
    begin
        rd_addr = HessAwL'(cmd.row * bqp_pkg::NumVars + cmd.col);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && in_word.action == bqp_pkg::ACT_HESS)
        begin
            hess_mem[HessAwL'(in_word.row * bqp_pkg::NumVars + in_word.column)]
                <= in_word.value;
        end
        h_rd_reg <= hess_mem[rd_addr];
    end

    // Vector loads.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            case (in_word.action)
                bqp_pkg::ACT_GRAD:  grad_reg[in_word.row[bqp_pkg::IdxW-1:0]]  <= in_word.value;
                bqp_pkg::ACT_LOWER: lower_reg[in_word.row[bqp_pkg::IdxW-1:0]] <= in_word.value;
                bqp_pkg::ACT_UPPER: upper_reg[in_word.row[bqp_pkg::IdxW-1:0]] <= in_word.value;
                default: ;
            endcase
        end
    end

    // The numerator, clamped to plus or minus 2^47-1, as a magnitude.
    always_comb
    begin
        num_full = -51'(grad_reg[cmd.row]) - sigma_reg;
        if (num_full > 51'sh7FFF_FFFF_FFFF)
            num_mag = 48'h7FFF_FFFF_FFFF;
        else if (num_full < -51'sh7FFF_FFFF_FFFF)
            num_mag = 48'h7FFF_FFFF_FFFF;
        else if (num_full < 0)
            num_mag = 48'(-num_full);
        else
            num_mag = 48'(num_full);
        trial = {rem_reg, quo_reg[63]} - {17'd0, diag_reg};
    end

    // Saturate the quotient, then clamp to the bounds (upper wins).
    always_comb
    begin
        quo_s = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        if (zero_reg)
            xnew = '0;
        else if (quo_s > 65'sd2147483647)
            xnew = 32'sh7FFF_FFFF;
        else if (quo_s < -65'sd2147483648)
            xnew = 32'sh8000_0000;
        else
            xnew = quo_s[31:0];
        if (xnew < lower_reg[cmd.row])
            xnew = lower_reg[cmd.row];
        if (xnew > upper_reg[cmd.row])
            xnew = upper_reg[cmd.row];
    end

    // Accumulation, restoring division (64 quotient bits, one per cycle).
    // The read word is registered from its column, and the product is registered from the read word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
            mac_d_reg    <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mac && (cmd.col != cmd.row);
            sum_vld_reg  <= prod_vld_reg;
            mac_d_reg    <= cmd.mac;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_x)
        begin
            for (int k = 0; k < bqp_pkg::NumVars; k++)
                x_reg[k] <= '0;
        end
        if (cmd.row_init)
            sigma_reg <= '0;
        col_d_reg <= cmd.col;
        // The diagonal is taken as it passes through the read port.
        if (mac_d_reg && col_d_reg == cmd.row)
            diag_reg <= h_rd_reg;
        prod_reg <= h_rd_reg * x_reg[col_d_reg];
        if (sum_vld_reg)
            sigma_reg <= sigma_reg + 51'(prod_reg >>> 16);
        if (cmd.num)
        begin
            neg_reg  <= (num_full < 0);
            zero_reg <= (diag_reg <= 0);
            quo_reg  <= {num_mag, 16'd0};
            rem_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            if (!trial[48])
            begin
                rem_reg <= trial[47:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[46:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (cmd.clamp)
            x_reg[cmd.row] <= xnew;
        out_word.var_index  <= 3'(cmd.row);
        out_word.step_value <= x_reg[cmd.row];
        out_word.last       <= cmd.emit_last;
    end

endmodule
`default_nettype wire

>>> src/bqp_ctrl.sv
// Controller: sequences sweeps, rows, division steps and result words.
`default_nettype none
module bqp_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire bqp_pkg::in_word_t in_word,
    input  wire logic [7:0]        sweeps,
    output logic                   busy,
    output logic                   done,
    output bqp_pkg::dp_cmd_t       cmd
);

    localparam int IW = bqp_pkg::IdxW;

    bqp_pkg::state_t state_reg, state_next;
    logic [7:0]    sweep_reg, sweep_next;
    logic [IW-1:0] row_reg, row_next;
    logic [IW-1:0] col_reg, col_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic          accept;
    logic          in_ok;

    assign accept = start && !busy;
    assign in_ok  = (in_word.row < 3'(bqp_pkg::NumVars)) &&
                    (in_word.action != bqp_pkg::ACT_HESS ||
                     in_word.column < 3'(bqp_pkg::NumVars));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            bqp_pkg::ST_IDLE:
            begin
                if (accept && in_word.action == bqp_pkg::ACT_SOLVE)
                begin
                    state_next = bqp_pkg::ST_CLEAR;
                    sweep_next = sweeps;
                    row_next   = '0;
                    col_next   = '0;
                end
            end
            bqp_pkg::ST_CLEAR:
            begin
                // Fetch the first diagonal while x is cleared.
                col_next   = '0;
                state_next = (sweep_reg == 8'd0) ? bqp_pkg::ST_EMIT : bqp_pkg::ST_ROW;
                if (sweep_reg != 8'd0)
                    col_next = row_reg;
            end
            bqp_pkg::ST_ROW:
            begin
                state_next = bqp_pkg::ST_MAC;
                col_next   = '0;
            end
            bqp_pkg::ST_MAC:
            begin
                if (col_reg == IW'(bqp_pkg::NumVars - 1))
                begin
                    state_next = bqp_pkg::ST_NUM;
                    cnt_next   = '0;
                end
                else
                    col_next = col_reg + 1'b1;
            end
            bqp_pkg::ST_NUM:
            begin
                // Drain the product pipeline, then load the divider.
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 7'd2)
                begin
                    state_next = bqp_pkg::ST_DIV;
                    cnt_next   = '0;
                end
            end
            bqp_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 7'd63)
                    state_next = bqp_pkg::ST_CLAMP;
            end
            bqp_pkg::ST_CLAMP:
            begin
                if (row_reg == IW'(bqp_pkg::NumVars - 1))
                begin
                    row_next = '0;
                    if (sweep_reg == 8'd1)
                        state_next = bqp_pkg::ST_EMIT;
                    else
                    begin
                        sweep_next = sweep_reg - 1'b1;
                        state_next = bqp_pkg::ST_ROW;
                        col_next   = '0;
                    end
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    col_next   = row_reg + 1'b1;
                    state_next = bqp_pkg::ST_ROW;
                end
            end
            bqp_pkg::ST_EMIT:
            begin
                done_next = 1'b1;
                if (row_reg == IW'(bqp_pkg::NumVars - 1))
                    state_next = bqp_pkg::ST_IDLE;
                else
                    row_next = row_reg + 1'b1;
            end
            default: state_next = bqp_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.row       = row_reg;
        cmd.col       = col_reg;
        cmd.emit_last = (row_reg == IW'(bqp_pkg::NumVars - 1));
        unique case (state_reg)
            bqp_pkg::ST_IDLE:
                cmd.load = accept && in_ok && in_word.action != bqp_pkg::ACT_SOLVE;
            bqp_pkg::ST_CLEAR: cmd.clear_x  = 1'b1;
            bqp_pkg::ST_ROW:   cmd.row_init = 1'b1;
            bqp_pkg::ST_MAC:   cmd.mac      = 1'b1;
            bqp_pkg::ST_NUM:   cmd.num      = (cnt_reg == 7'd2);
            bqp_pkg::ST_DIV:   cmd.div_step = 1'b1;
            bqp_pkg::ST_CLAMP: cmd.clamp    = 1'b1;
            bqp_pkg::ST_EMIT:  cmd.emit     = 1'b1;
            default: ;
        endcase
    end

    assign busy = (state_reg != bqp_pkg::ST_IDLE);
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bqp_pkg::ST_IDLE;
            sweep_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // No load word is taken while a solve is running.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.load) else $error("load while busy");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bqp_pkg::ST_CLAMP) |-> $past(state_reg) == bqp_pkg::ST_DIV)
        else $error("clamp without division");
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> done) else $error("emit lost");

endmodule
`default_nettype wire

>>> src/box_qp_gauss_seidel_solver.sv
// Top level of the projected Gauss-Seidel box-constrained QP solver.
//
//  channel   | signals                  | flow
//  ----------+--------------------------+------------------------------
//  command   | start, busy, cmd_word    | word in when start && !busy
//  result    | result_valid, result_word| one word per cycle, no stall
//  config    | cfg_we, cfg_data         | sweep count, written any edge
//
// Loads leave the block idle. A solve clears x, then in each sweep takes
// every row through setup, the multiply-accumulate, draining, the bit-serial
// divider and the clamp, and then emits the result words.
// Reset clears control state and sets the sweep count to ten.
// Six result words leave on consecutive cycles; the receiver cannot stall.
`default_nettype none
module box_qp_gauss_seidel_solver
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire bqp_pkg::in_word_t cmd_word,
    output logic                   busy,
    output logic                   result_valid,
    output bqp_pkg::out_word_t     result_word,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_data
);

    logic [7:0]       sweep_reg;
    bqp_pkg::dp_cmd_t cmd;

    // Sweep count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_reg <= bqp_pkg::SweepReset;
        else if (cfg_we)
            sweep_reg <= cfg_data;
    end

    bqp_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_word (cmd_word),
        .sweeps  (sweep_reg),
        .busy    (busy),
        .done    (result_valid),
        .cmd     (cmd)
    );

    bqp_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_word  (cmd_word),
        .out_word (result_word)
    );

endmodule
`default_nettype wire

>>> tb/box_qp_gauss_seidel_solver_test.sv
// Self-checking testbench for the box-constrained QP solver: loads, solves and sweep settings.
`default_nettype none
module box_qp_gauss_seidel_solver_test;

    localparam int StallLimit = 400000;

    // One pending entry: either a command word or a sweep count write.
    typedef struct {
        bit                idx_cfg;
        bqp_pkg::in_word_t word;
        logic [7:0]        sweeps;
    } pending_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    bqp_pkg::in_word_t  cmd_word;
    logic               busy;
    logic               result_valid;
    bqp_pkg::out_word_t result_word;
    logic               cfg_we;
    logic [7:0]         cfg_data;

    pending_t           pending_q[$];
    bqp_pkg::out_word_t solution_q[$];

    // Predicted contents of the block.
    logic signed [31:0] hess_m [bqp_pkg::NumVars][bqp_pkg::NumVars];
    logic signed [31:0] grad_v [bqp_pkg::NumVars];
    logic signed [31:0] lo_v   [bqp_pkg::NumVars];
    logic signed [31:0] hi_v   [bqp_pkg::NumVars];
    logic signed [31:0] x_v    [bqp_pkg::NumVars];
    logic [7:0]         sweeps_now;

    int  errors = 0;
    bit  taken = 0;
    bit  stim_done = 0;
    int  gap_left = 0;
    int  quiet = 0;
    int  stall_count = 0;

    box_qp_gauss_seidel_solver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd_word     (cmd_word),
        .busy         (busy),
        .result_valid (result_valid),
        .result_word  (result_word),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    // Clock: period of 20.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // One projected relaxation step of variable i.
    function automatic logic signed [31:0] relax_var(int i);
        longint sigma;
        longint diag;
        longint num;
        longint quot;
        longint lim;
        logic signed [31:0] x;
        sigma = 0;
        lim = (64'sd1 <<< 47) - 1;
        diag = longint'(hess_m[i][i]);
        for (int j = 0; j < bqp_pkg::NumVars; j++)
        begin
            if (j != i)
                sigma += (longint'(hess_m[i][j]) * longint'(x_v[j])) >>> 16;
        end
        num = -longint'(grad_v[i]) - sigma;
        x = 32'sd0;
        if (diag > 0)
        begin
            if (num > lim) num = lim;
            if (num < -lim) num = -lim;
            quot = (num * 65536) / diag;
            if (quot > 64'sd2147483647) x = 32'sh7fffffff;
            else if (quot < -64'sd2147483648) x = 32'sh80000000;
            else x = quot[31:0];
        end
        if (x < lo_v[i]) x = lo_v[i];
        if (x > hi_v[i]) x = hi_v[i];
        return x;
    endfunction

    // Apply one accepted word to the predicted state and queue any solution words.
    task automatic predict_word(bqp_pkg::in_word_t w);
        bqp_pkg::out_word_t r;
        if (w.action == bqp_pkg::ACT_SOLVE)
        begin
            for (int i = 0; i < bqp_pkg::NumVars; i++) x_v[i] = 32'sd0;
            for (int s = 0; s < sweeps_now; s++)
                for (int i = 0; i < bqp_pkg::NumVars; i++)
                    x_v[i] = relax_var(i);
            for (int i = 0; i < bqp_pkg::NumVars; i++)
            begin
                r.var_index  = i[2:0];
                r.step_value = x_v[i];
                r.last       = (i == bqp_pkg::NumVars - 1);
                solution_q.push_back(r);
            end
        end
        else if (w.action <= bqp_pkg::ACT_UPPER && w.row < bqp_pkg::NumVars)
        begin
            case (w.action)
                bqp_pkg::ACT_HESS:
                    if (w.column < bqp_pkg::NumVars) hess_m[w.row][w.column] = w.value;
                bqp_pkg::ACT_GRAD:  grad_v[w.row] = w.value;
                bqp_pkg::ACT_LOWER: lo_v[w.row] = w.value;
                default:            hi_v[w.row] = w.value;
            endcase
        end
    endtask

    // Monitor: record acceptance, update the prediction and check solution words.
    always @(posedge clk)
    begin
        taken = rst_n && start && !busy;
        if (rst_n && cfg_we)
            sweeps_now = cfg_data;
        if (taken)
            predict_word(cmd_word);
        if (rst_n && result_valid)
        begin
            if (solution_q.size() == 0)
            begin
                $error("unexpected solution word index %0d value %0d",
                       result_word.var_index, result_word.step_value);
                errors++;
            end
            else
            begin
                bqp_pkg::out_word_t e;
                e = solution_q.pop_front();
                if (result_word.var_index !== e.var_index)
                begin
                    $error("var_index expected %0d actual %0d", e.var_index,
                           result_word.var_index);
                    errors++;
                end
                if (result_word.step_value !== e.step_value)
                begin
                    $error("step_value expected %0d actual %0d", e.step_value,
                           result_word.step_value);
                    errors++;
                end
                if (result_word.last !== e.last)
                begin
                    $error("last expected %0b actual %0b", e.last, result_word.last);
                    errors++;
                end
            end
        end
        // Watchdog on cycles in which nothing moves.
        if (taken || result_valid || cfg_we)
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= StallLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Driver: presents words at the falling edge with random gaps.
    always @(negedge clk)
    begin
        logic next_start;
        logic next_we;
        int   roll;
        next_start = start;
        next_we = 1'b0;
        if (taken)
            next_start = 1'b0;
        if (!busy && solution_q.size() == 0)
            quiet++;
        else
            quiet = 0;
        if (rst_n && !next_start)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_q.size() > 0)
            begin
                roll = $urandom_range(0, 9);
                if (pending_q[0].idx_cfg)
                begin
                    // Sweep count changes only once the block has gone quiet.
                    if (quiet >= 16)
                    begin
                        next_we = 1'b1;
                        cfg_data <= pending_q[0].sweeps;
                        void'(pending_q.pop_front());
                    end
                end
                else
                begin
                    next_start = 1'b1;
                    cmd_word <= pending_q[0].word;
                    void'(pending_q.pop_front());
                    gap_left = (roll < 6) ? 0 : (roll < 9) ? $urandom_range(1, 3)
                                                           : $urandom_range(10, 40);
                end
            end
            else
                stim_done = 1;
        end
        start  <= next_start;
        cfg_we <= next_we;
    end

    task automatic add_word(logic [2:0] act, logic [2:0] r, logic [2:0] c,
                            logic signed [31:0] v);
        pending_t p;
        p.idx_cfg = 0;
        p.word.action = act;
        p.word.row = r;
        p.word.column = c;
        p.word.value = v;
        p.sweeps = 8'd0;
        pending_q.push_back(p);
    endtask

    task automatic add_sweeps(logic [7:0] n);
        pending_t p;
        p.idx_cfg = 1;
        p.word = '0;
        p.sweeps = n;
        pending_q.push_back(p);
    endtask

    // Random Q16.16 value: mostly modest, sometimes extreme or fully random.
    function automatic logic signed [31:0] rand_val();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 32'sh7fffffff;
        if (k == 1) return 32'sh80000000;
        if (k < 4) return $urandom();
        return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endfunction

    // A well-formed problem: positive, diagonally dominant Hessian.
    task automatic add_problem();
        for (int i = 0; i < bqp_pkg::NumVars; i++)
        begin
            for (int j = 0; j < bqp_pkg::NumVars; j++)
            begin
                if (i == j)
                    add_word(bqp_pkg::ACT_HESS, 3'(i), 3'(j),
                             $urandom_range(32'h0006_0000, 32'h0010_0000));
                else
                    add_word(bqp_pkg::ACT_HESS, 3'(i), 3'(j),
                             $signed($urandom_range(0, 32'h0001_0000)) - 32'sh0000_8000);
            end
            add_word(bqp_pkg::ACT_GRAD, 3'(i), 3'd0, rand_val());
            add_word(bqp_pkg::ACT_LOWER, 3'(i), 3'd0,
                     -$signed($urandom_range(0, 32'h0004_0000)));
            add_word(bqp_pkg::ACT_UPPER, 3'(i), 3'd0, $urandom_range(0, 32'h0004_0000));
        end
    endtask

    // Random phase: mostly small edits followed by a solve, the rest noise.
    task automatic add_random_phase(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                repeat ($urandom_range(0, 6))
                begin
                    add_word(3'($urandom_range(bqp_pkg::ACT_HESS, bqp_pkg::ACT_UPPER)),
                             3'($urandom_range(0, 5)), 3'($urandom_range(0, 5)),
                             rand_val());
                    n++;
                end
                add_word(bqp_pkg::ACT_SOLVE, 3'($urandom()), 3'($urandom()), $urandom());
                n++;
            end
            else
            begin
                add_word(3'($urandom()), 3'($urandom()), 3'($urandom()), $urandom());
                n++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd_word = '0;
        cfg_we = 1'b0;
        cfg_data = 8'd0;
        sweeps_now = bqp_pkg::SweepReset;
        for (int i = 0; i < bqp_pkg::NumVars; i++)
        begin
            grad_v[i] = 0;
            lo_v[i] = 0;
            hi_v[i] = 0;
            x_v[i] = 0;
            for (int j = 0; j < bqp_pkg::NumVars; j++) hess_m[i][j] = 0;
        end

        // Every store entry is written before the first solve.
        add_problem();
        add_word(bqp_pkg::ACT_SOLVE, 3'd0, 3'd0, 32'sd0);
        // Zero and negative diagonals, lower above upper, saturating gradients.
        add_word(bqp_pkg::ACT_HESS, 3'd0, 3'd0, 32'sd0);
        add_word(bqp_pkg::ACT_HESS, 3'd1, 3'd1, 32'sh80000000);
        add_word(bqp_pkg::ACT_LOWER, 3'd2, 3'd0, 32'sh0001_0000);
        add_word(bqp_pkg::ACT_UPPER, 3'd2, 3'd0, -32'sh0001_0000);
        add_word(bqp_pkg::ACT_HESS, 3'd3, 3'd3, 32'sd1);
        add_word(bqp_pkg::ACT_GRAD, 3'd3, 3'd0, 32'sh80000000);
        add_word(bqp_pkg::ACT_LOWER, 3'd3, 3'd0, 32'sh80000000);
        add_word(bqp_pkg::ACT_UPPER, 3'd3, 3'd0, 32'sh7fffffff);
        add_word(bqp_pkg::ACT_GRAD, 3'd4, 3'd0, 32'sh7fffffff);
        add_word(bqp_pkg::ACT_LOWER, 3'd4, 3'd0, 32'sh80000000);
        add_word(bqp_pkg::ACT_HESS, 3'd5, 3'd4, 32'sh7fffffff);
        // Out-of-range indices and unknown actions are ignored.
        add_word(bqp_pkg::ACT_HESS, 3'd6, 3'd0, 32'sh1234_5678);
        add_word(bqp_pkg::ACT_HESS, 3'd0, 3'd7, 32'sh1234_5678);
        add_word(bqp_pkg::ACT_GRAD, 3'd7, 3'd0, 32'sh7fffffff);
        add_word(3'd5, 3'd0, 3'd0, 32'sh7fffffff);
        add_word(3'd6, 3'd7, 3'd7, 32'shffffffff);
        add_word(3'd7, 3'd5, 3'd5, 32'sh0);
        add_word(bqp_pkg::ACT_SOLVE, 3'd7, 3'd7, 32'shffffffff);
        add_sweeps(8'd1);
        add_word(bqp_pkg::ACT_SOLVE, 3'd0, 3'd0, 32'sd0);
        add_sweeps(8'd0);
        add_word(bqp_pkg::ACT_SOLVE, 3'd0, 3'd0, 32'sd0);
        add_sweeps(8'd255);
        add_word(bqp_pkg::ACT_SOLVE, 3'd0, 3'd0, 32'sd0);

        // Random phases at assorted small sweep counts.
        add_sweeps(8'd2);
        add_random_phase(8);
        add_sweeps(8'($urandom_range(1, 6)));
        add_problem();
        add_random_phase(8);
        add_sweeps(8'd10);
        add_random_phase(8);
        add_sweeps(8'($urandom_range(3, 8)));
        add_random_phase(8);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (stim_done && solution_q.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && solution_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
